### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the RTL in this folder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion on an explicit clock and active-low reset.
`define ASSERT_CR(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Assertion on the usual clk_i and rst_ni of the enclosing module.
`define ASSERT_STD(lbl, prop, msg) `ASSERT_CR(lbl, clk_i, rst_ni, prop, msg)

`endif

### rtl/core/mtflru_pkg.sv
// ----------------------------------------------------------------------------
// mtflru_pkg
// Types and constants shared by the move-to-front LRU cache.
// ----------------------------------------------------------------------------
package mtflru_pkg;

  // Default number of cache entries.
  localparam int CAPACITY_DEF = 64;

  localparam int KEY_W    = 32;
  localparam int HANDLE_W = 32;

  typedef enum logic {
    KIND_LOOKUP  = 1'b0,
    KIND_INSTALL = 1'b1
  } kind_e;

  // Request item.
  typedef struct packed {
    kind_e               kind;
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
  } req_t;

  // Result item.
  typedef struct packed {
    logic                hit;
    logic [HANDLE_W-1:0] found_handle;
    logic                evicted;
    logic [HANDLE_W-1:0] evicted_handle;
  } rsp_t;

  // One stored cache entry.
  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

### rtl/core/mtflru_ram.sv
// ----------------------------------------------------------------------------
// mtflru_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module mtflru_ram #(
  parameter int Width = mtflru_pkg::ENTRY_W,
  parameter int Depth = mtflru_pkg::CAPACITY_DEF,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/move_to_front_lru_cache.sv
// ----------------------------------------------------------------------------
// move_to_front_lru_cache
// Move-to-front list of (key, handle) pairs held in one synchronous RAM.
// ----------------------------------------------------------------------------
// Usage: requests arrive on the in channel (valid/ready); each item is either
// a lookup of a key or an install of a key and handle at the front of the
// list. Every item yields exactly one result item on the out channel.
// Latency depends on the list: a lookup scans the RAM one entry a cycle. A
// hit at the front leaves the order as it is, and a hit further back is
// followed by a shift of the entries in front of it. An install shifts the
// filled list back one slot; for a full list the read of the last entry for
// eviction replaces one step of the shift.
// Latency is set by the single read port and single write port of the
// entry RAM.
// Reset empties the list at once (the fill count is cleared; the RAM is not
// swept). The block takes a new item as soon as the previous result sits in
// the output register, so a stalled receiver holds back at most one item:
// the next result waits inside the block until the output register frees.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module move_to_front_lru_cache #(
  parameter int CAPACITY = mtflru_pkg::CAPACITY_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  mtflru_pkg::req_t  in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output mtflru_pkg::rsp_t  out_o
);

  // Address width of the entry RAM and width of a count that can hold CAPACITY.
  localparam int IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CntW = $clog2(CAPACITY + 1);

  localparam logic [CntW-1:0] CntFull = CntW'(CAPACITY);
  localparam logic [CntW-1:0] CntLast = CntW'(CAPACITY - 1);
  localparam logic [IdxW-1:0] IdxLast = IdxW'(CAPACITY - 1);

  typedef enum logic [2:0] {
    ST_IDLE,   // waiting for an item
    ST_SCAN,   // lookup: reading entries front to back
    ST_EVCAP,  // full install: catching the handle of the last entry
    ST_SHIFT,  // moving entries back by one slot
    ST_FRONT,  // writing the new front entry
    ST_RESP    // handing the result to the output register
  } state_e;

  state_e               state_q, state_d;
  mtflru_pkg::req_t     req_q, req_d;
  mtflru_pkg::rsp_t     rsp_q, rsp_d;
  mtflru_pkg::rsp_t     out_q, out_d;
  logic                 out_valid_q, out_valid_d;
  mtflru_pkg::entry_t   front_q, front_d;
  logic [CntW-1:0]      fill_q, fill_d;
  logic [CntW-1:0]      rd_ptr_q, rd_ptr_d;
  logic                 cmp_vld_q, cmp_vld_d;
  logic [IdxW-1:0]      cmp_idx_q, cmp_idx_d;
  logic                 wr_pend_q, wr_pend_d;
  logic [IdxW-1:0]      wr_addr_q, wr_addr_d;

  // Entry RAM port signals.
  logic                 ram_we, ram_re;
  logic [IdxW-1:0]      ram_waddr, ram_raddr;
  mtflru_pkg::entry_t   ram_wdata, ram_rdata;

  mtflru_ram #(
    .Width (mtflru_pkg::ENTRY_W),
    .Depth (CAPACITY)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Next-state logic. Reads and writes never touch the same slot in one
  // cycle: during a shift the read runs two slots ahead of the write, and
  // the scan and eviction read never coincide with a write, so no forwarding
  // path is needed.
  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    rsp_d       = rsp_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    front_d     = front_q;
    fill_d      = fill_q;
    rd_ptr_d    = rd_ptr_q;
    cmp_vld_d   = 1'b0;
    cmp_idx_d   = cmp_idx_q;
    wr_pend_d   = 1'b0;
    wr_addr_d   = wr_addr_q;

    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = front_q;
    ram_re      = 1'b0;
    ram_raddr   = '0;

    // The output register empties when the receiver takes the item.
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          req_d    = in_i;
          rsp_d    = '0;
          rd_ptr_d = '0;
          front_d  = '{key: in_i.key, handle: in_i.handle};
          if (in_i.kind == mtflru_pkg::KIND_LOOKUP) begin
            state_d = (fill_q == '0) ? ST_RESP : ST_SCAN;
          end else if (fill_q == CntFull) begin
            // Full list: read the last entry before it is overwritten.
            ram_re    = 1'b1;
            ram_raddr = IdxLast;
            state_d   = ST_EVCAP;
          end else if (fill_q == '0) begin
            state_d = ST_FRONT;
          end else begin
            rd_ptr_d = fill_q;
            state_d  = ST_SHIFT;
          end
        end
      end

      ST_SCAN: begin
        // Issue one read a cycle; compare the data in the next cycle.
        if (rd_ptr_q < fill_q) begin
          ram_re    = 1'b1;
          ram_raddr = rd_ptr_q[IdxW-1:0];
          rd_ptr_d  = rd_ptr_q + CntW'(1);
          cmp_vld_d = 1'b1;
          cmp_idx_d = rd_ptr_q[IdxW-1:0];
        end
        if (cmp_vld_q && (ram_rdata.key == req_q.key)) begin
          front_d            = ram_rdata;
          rsp_d.hit          = 1'b1;
          rsp_d.found_handle = ram_rdata.handle;
          cmp_vld_d          = 1'b0;
          if (cmp_idx_q == '0) begin
            // Hit at the front: the order stays as it is.
            state_d = ST_RESP;
          end else begin
            rd_ptr_d = CntW'(cmp_idx_q);
            state_d  = ST_SHIFT;
          end
        end else if (cmp_vld_q && ((CntW'(cmp_idx_q) + CntW'(1)) == fill_q)) begin
          cmp_vld_d = 1'b0;
          state_d   = ST_RESP;
        end
      end

      ST_EVCAP: begin
        rsp_d.evicted        = 1'b1;
        rsp_d.evicted_handle = ram_rdata.handle;
        rd_ptr_d             = CntLast;
        state_d              = ST_SHIFT;
      end

      ST_SHIFT: begin
        // rd_ptr_q is the slot that the entry read now will land in.
        if (wr_pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = wr_addr_q;
          ram_wdata = ram_rdata;
        end
        if (rd_ptr_q != '0) begin
          ram_re    = 1'b1;
          ram_raddr = IdxW'(rd_ptr_q - CntW'(1));
          wr_pend_d = 1'b1;
          wr_addr_d = rd_ptr_q[IdxW-1:0];
          rd_ptr_d  = rd_ptr_q - CntW'(1);
        end else begin
          state_d = ST_FRONT;
        end
      end

      ST_FRONT: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = front_q;
        if ((req_q.kind == mtflru_pkg::KIND_INSTALL) && (fill_q != CntFull)) begin
          fill_d = fill_q + CntW'(1);
        end
        state_d = ST_RESP;
      end

      ST_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = rsp_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      req_q       <= '0;
      rsp_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
      front_q     <= '0;
      fill_q      <= '0;
      rd_ptr_q    <= '0;
      cmp_vld_q   <= 1'b0;
      cmp_idx_q   <= '0;
      wr_pend_q   <= 1'b0;
      wr_addr_q   <= '0;
    end else begin
      state_q     <= state_d;
      req_q       <= req_d;
      rsp_q       <= rsp_d;
      out_q       <= out_d;
      out_valid_q <= out_valid_d;
      front_q     <= front_d;
      fill_q      <= fill_d;
      rd_ptr_q    <= rd_ptr_d;
      cmp_vld_q   <= cmp_vld_d;
      cmp_idx_q   <= cmp_idx_d;
      wr_pend_q   <= wr_pend_d;
      wr_addr_q   <= wr_addr_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // The fill count never passes the capacity.
  `ASSERT_STD(a_fill_bound, fill_q <= CntFull, "fill count exceeds capacity")
  // A read and a write never address the same slot in one cycle.
  `ASSERT_STD(a_no_rw_clash, !(ram_we && ram_re && (ram_waddr == ram_raddr)),
              "entry RAM read and write collide")
  // Eviction is only started from a full list.
  `ASSERT_STD(a_evict_full, (state_q == ST_EVCAP) |-> (fill_q == CntFull),
              "eviction with a list that is not full")
  // A result is never both a hit and an eviction.
  `ASSERT_STD(a_rsp_exclusive, out_valid_o |-> !(out_o.hit && out_o.evicted),
              "result flags both hit and eviction")

endmodule
